// ===== hw/rtl/sha256_message_digest_macros.svh =====
// Assertion macros for the SHA-256 digest block.
// Included by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle property, checked out of reset.
`define SMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/smd_pkg.sv =====
// Shared types and constants for the SHA-256 digest block.
// Used by smd_core and sha256_message_digest; no dependencies.
package smd_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos = 56;

  localparam logic [7:0] PadMarker = 8'h80;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConst [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Control from the byte sequencer to the compression unit.
  typedef struct packed {
    logic start;
    logic restart;
  } core_ctl_t;

  // Status back from the compression unit.
  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  function automatic word_t ror32(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== hw/rtl/sha256_message_digest.sv =====
// SHA-256 over a byte stream. Byte beats are taken while idle; a full block
// then holds off input through load, 64 rounds on one round unit and add.
// End of message shifts in 0x80, zero fill and the length one byte a cycle,
// then emits eight digest beats. Reset restores the initial hash value and
// clears the byte count and bit length.
module sha256_message_digest
  import smd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        final_word_o
);

  `include "sha256_message_digest_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COMP = 2'd1;
  localparam logic [1:0] S_PAD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [5:0] LastFill = 6'(BlockBytes - 1);
  localparam logic [5:0] LenFill  = 6'(LenPos);

  logic [1:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic        eom_q, eom_d;
  logic        pad_first_q, pad_first_d;
  logic        len_ok_q, len_ok_d;
  logic        final_blk_q, final_blk_d;
  logic        start_q, start_d;
  logic        restart_q, restart_d;
  logic [2:0]  idx_q, idx_d;

  logic [7:0]        blk_q [BlockBytes];
  logic              shift_en;
  logic [7:0]        shift_byte;
  logic [2:0]        len_sel;
  logic [15:0][31:0] blk_words;
  logic [7:0][31:0]  chain;
  core_ctl_t         core_ctl;
  core_sts_t         core_sts;

  assign len_sel = 3'd7 - fill_q[2:0];

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    len_d       = len_q;
    eom_d       = eom_q;
    pad_first_d = pad_first_q;
    len_ok_d    = len_ok_q;
    final_blk_d = final_blk_q;
    idx_d       = idx_q;
    start_d     = 1'b0;
    restart_d   = 1'b0;
    shift_en    = 1'b0;
    shift_byte  = data_byte_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (has_byte_i) begin
            shift_en = 1'b1;
            fill_d   = fill_q + 6'd1;
            len_d    = len_q + 64'd8;
          end
          if (has_byte_i && fill_q == LastFill) begin
            start_d     = 1'b1;
            state_d     = S_COMP;
            eom_d       = end_of_message_i;
            pad_first_d = end_of_message_i;
            final_blk_d = 1'b0;
          end else if (end_of_message_i) begin
            state_d     = S_PAD;
            pad_first_d = 1'b1;
          end
        end
      end
      S_PAD: begin
        shift_en = 1'b1;
        fill_d   = fill_q + 6'd1;
        if (pad_first_q) begin
          shift_byte  = PadMarker;
          pad_first_d = 1'b0;
          len_ok_d    = (fill_q < LenFill);
        end else if (len_ok_q && fill_q >= LenFill) begin
          shift_byte = len_q[{len_sel, 3'b000} +: 8];
        end else begin
          shift_byte = '0;
        end
        if (fill_q == LastFill) begin
          start_d     = 1'b1;
          state_d     = S_COMP;
          eom_d       = 1'b1;
          final_blk_d = len_ok_q && !pad_first_q;
        end
      end
      S_COMP: begin
        if (core_sts.done) begin
          if (final_blk_q) begin
            state_d = S_OUT;
            idx_d   = '0;
          end else if (eom_q) begin
            // Spill block done; the next one carries the length.
            state_d  = S_PAD;
            len_ok_d = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d   = S_IDLE;
            restart_d = 1'b1;
            fill_d    = '0;
            len_d     = '0;
            eom_d     = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      len_q       <= '0;
      eom_q       <= 1'b0;
      pad_first_q <= 1'b0;
      len_ok_q    <= 1'b0;
      final_blk_q <= 1'b0;
      start_q     <= 1'b0;
      restart_q   <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      eom_q       <= eom_d;
      pad_first_q <= pad_first_d;
      len_ok_q    <= len_ok_d;
      final_blk_q <= final_blk_d;
      start_q     <= start_d;
      restart_q   <= restart_d;
      idx_q       <= idx_d;
    end
  end

  // Byte shift line: oldest byte ends up at index 0 after a full block.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < BlockBytes - 1; i++) begin
        blk_q[i] <= blk_q[i + 1];
      end
      blk_q[BlockBytes - 1] <= shift_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      blk_words[i] = {blk_q[4 * i], blk_q[4 * i + 1], blk_q[4 * i + 2], blk_q[4 * i + 3]};
    end
  end

  assign core_ctl.start   = start_q;
  assign core_ctl.restart = restart_q;

  smd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (core_ctl),
    .block_i (blk_words),
    .sts_o   (core_sts),
    .chain_o (chain)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign digest_word_o = chain[idx_q];
  assign word_index_o  = idx_q;
  assign final_word_o  = (idx_q == 3'd7);

  `SMD_ASSERT(a_no_out_while_ready, out_valid_o |-> in_stall_o, "digest beat while accepting input")
  `SMD_ASSERT(a_start_when_idle, core_ctl.start |-> !core_sts.busy, "compression started while busy")
  `SMD_ASSERT(a_start_full_block, core_ctl.start |-> (fill_q == '0), "compression on partial block")
  `SMD_ASSERT_NEXT(a_ready_after_last, out_valid_o && !out_stall_i && final_word_o, !in_stall_o && fill_q == '0, "not ready after last digest beat")

endmodule

// ===== hw/rtl/smd_core.sv =====
// SHA-256 compression unit: one round per cycle, rolling 16-word schedule window.
// Holds the chaining words. Depends on smd_pkg.
module smd_core import smd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  core_ctl_t             ctl_i,
  input  logic [15:0][31:0]     block_i,
  output core_sts_t             sts_o,
  output logic [7:0][31:0]      chain_o
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RUN  = 2'd1;
  localparam logic [1:0] C_ADD  = 2'd2;

  localparam logic [5:0] LastRound = 6'(NumRounds - 1);

  logic [1:0]        state_q, state_d;
  logic [5:0]        rnd_q, rnd_d;
  logic [7:0][31:0]  chain_q;
  logic [7:0][31:0]  regs_q;
  logic [15:0][31:0] win_q;

  word_t t1, t2, next_w, ch, maj;

  always_comb begin
    ch     = (regs_q[4] & regs_q[5]) ^ (~regs_q[4] & regs_q[6]);
    maj    = (regs_q[0] & regs_q[1]) ^ (regs_q[0] & regs_q[2]) ^ (regs_q[1] & regs_q[2]);
    t1     = regs_q[7] + big_sigma1(regs_q[4]) + ch + RoundConst[rnd_q] + win_q[0];
    t2     = big_sigma0(regs_q[0]) + maj;
    next_w = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    case (state_q)
      C_IDLE: begin
        if (ctl_i.start) begin
          state_d = C_RUN;
          rnd_d   = '0;
        end
      end
      C_RUN: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LastRound) begin
          state_d = C_ADD;
        end
      end
      C_ADD: begin
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= InitHash[i];
      end
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      if (state_q == C_IDLE && ctl_i.restart) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= InitHash[i];
        end
      end else if (state_q == C_ADD) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + regs_q[i];
        end
      end
    end
  end

  // Working variables and schedule window carry no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && ctl_i.start) begin
      win_q  <= block_i;
      regs_q <= chain_q;
    end else if (state_q == C_RUN) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[15] <= next_w;
      regs_q[7] <= regs_q[6];
      regs_q[6] <= regs_q[5];
      regs_q[5] <= regs_q[4];
      regs_q[4] <= regs_q[3] + t1;
      regs_q[3] <= regs_q[2];
      regs_q[2] <= regs_q[1];
      regs_q[1] <= regs_q[0];
      regs_q[0] <= t1 + t2;
    end
  end

  assign sts_o.busy = (state_q != C_IDLE);
  assign sts_o.done = (state_q == C_ADD);
  assign chain_o    = chain_q;

endmodule

// ===== sim/sha256_message_digest_tb.sv =====
// Self-checking testbench for sha256_message_digest: byte beats in, digest word beats out.
// Needs only the RTL; a built-in SHA-256 predictor or known digest checks each word.
module sha256_message_digest_tb;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 800;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned ByteTarget  = 500;

  localparam logic [255:0] EmptyDigest =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {KnownNone, KnownEmpty, KnownAbc} known_digest_e;
  typedef enum logic [1:0] {StallNone, StallRandom, StallPeriodic} stall_mode_e;

  typedef struct packed {
    logic [7:0]    data;
    logic          has;
    logic          eom;
    known_digest_e known;
  } byte_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  localparam int unsigned NumRows = 19;
  localparam byte_row_t DirectedRows [NumRows] = '{
    '{8'h00, 1'b0, 1'b1, KnownEmpty},  // empty message right after reset
    '{8'h5a, 1'b0, 1'b0, KnownNone},   // idle beat, junk data
    '{8'h61, 1'b1, 1'b0, KnownNone},
    '{8'hff, 1'b0, 1'b0, KnownNone},
    '{8'h62, 1'b1, 1'b0, KnownNone},
    '{8'h63, 1'b1, 1'b1, KnownAbc},    // last byte carries the end mark
    '{8'h00, 1'b1, 1'b1, KnownNone},
    '{8'hff, 1'b1, 1'b1, KnownNone},
    '{8'ha5, 1'b0, 1'b1, KnownEmpty},  // empty final beat, data ignored
    '{8'h61, 1'b1, 1'b0, KnownNone},
    '{8'h62, 1'b1, 1'b0, KnownNone},
    '{8'h63, 1'b1, 1'b0, KnownNone},
    '{8'h3c, 1'b0, 1'b1, KnownAbc},    // bytes closed by an empty final beat
    '{8'hff, 1'b1, 1'b0, KnownNone},
    '{8'h00, 1'b1, 1'b0, KnownNone},
    '{8'hff, 1'b1, 1'b0, KnownNone},
    '{8'h80, 1'b1, 1'b0, KnownNone},
    '{8'h00, 1'b0, 1'b0, KnownNone},
    '{8'h7f, 1'b1, 1'b1, KnownNone}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        has_byte_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        final_word_o;

  sha256_message_digest i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .final_word_o     (final_word_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] hash_words [8];
  logic [7:0]  block_data [64];
  int unsigned block_fill;
  logic [63:0] message_bits;

  digest_beat_t pending_words [$];
  digest_beat_t expected_beat;
  int unsigned  error_count;
  int unsigned  bytes_sent;
  int unsigned  burst_left;
  int unsigned  cycle_count;
  logic         hold_out_req;
  stall_mode_e  stall_mode;
  int unsigned  stall_left;

  function automatic logic [31:0] rot_r(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_hash();
    int i;
    for (i = 0; i < 8; i++) hash_words[i] = StartHash[i];
    block_fill = 0;
    message_bits = '0;
  endtask

  task automatic compress_block_model();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, ch, maj, t1, t2;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {block_data[4*i], block_data[4*i+1], block_data[4*i+2], block_data[4*i+3]};
    for (i = 16; i < 64; i++) begin
      s0 = rot_r(w[i-15], 7) ^ rot_r(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rot_r(w[i-2], 17) ^ rot_r(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (i = 0; i < 8; i++) v[i] = hash_words[i];
    for (i = 0; i < 64; i++) begin
      s1  = rot_r(v[4], 6) ^ rot_r(v[4], 11) ^ rot_r(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + RoundK[i] + w[i];
      s0  = rot_r(v[0], 2) ^ rot_r(v[0], 13) ^ rot_r(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2  = s0 + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) hash_words[i] = hash_words[i] + v[i];
  endtask

  // Fold one beat into the running hash; on end of message return the digest.
  task automatic absorb_beat(input logic [7:0] d, input logic h, input logic e,
                             output logic done, output logic [255:0] digest);
    int unsigned pos;
    int i;
    done = 1'b0;
    digest = '0;
    if (h) begin
      block_data[block_fill] = d;
      block_fill++;
      message_bits = message_bits + 64'd8;
      if (block_fill == 64) begin
        compress_block_model();
        block_fill = 0;
      end
    end
    if (e) begin
      pos = block_fill;
      block_data[pos] = 8'h80;
      pos++;
      // length no longer fits: close this block and pad a fresh one
      if (pos > 56) begin
        while (pos < 64) begin
          block_data[pos] = 8'h00;
          pos++;
        end
        compress_block_model();
        pos = 0;
      end
      while (pos < 56) begin
        block_data[pos] = 8'h00;
        pos++;
      end
      for (i = 0; i < 8; i++) block_data[56+i] = message_bits[63-8*i -: 8];
      compress_block_model();
      for (i = 0; i < 8; i++) digest[255-32*i -: 32] = hash_words[i];
      done = 1'b1;
      restart_hash();
    end
  endtask

  task automatic queue_digest(input logic [255:0] digest);
    int i;
    digest_beat_t beat;
    for (i = 0; i < 8; i++) begin
      beat = '{digest[255-32*i -: 32], i[2:0], (i == 7)};
      pending_words = {pending_words, beat};
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [7:0] d, input logic h, input logic e,
                           input known_digest_e known);
    logic         done;
    logic [255:0] digest;
    in_valid_i       = 1'b1;
    data_byte_i      = d;
    has_byte_i       = h;
    end_of_message_i = e;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    absorb_beat(d, h, e, done, digest);
    if (done) begin
      case (known)
        KnownEmpty: queue_digest(EmptyDigest);
        KnownAbc:   queue_digest(AbcDigest);
        default:    queue_digest(digest);
      endcase
    end
    if (h) bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid_i  = 1'b0;
      data_byte_i = 8'($urandom);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic drain_digests();
    in_valid_i = 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 11);
    case (sel)
      0, 1:    return $urandom_range(0, 3);
      2:       return $urandom_range(55, 56);
      3:       return $urandom_range(63, 65);
      4:       return ($urandom_range(0, 1) == 1) ? $urandom_range(119, 120)
                                                  : $urandom_range(127, 128);
      default: return $urandom_range(4, 40);
    endcase
  endfunction

  // Random message with idle noise; some close on an empty final beat.
  task automatic send_message(input int unsigned len);
    logic        empty_close;
    int unsigned i;
    empty_close = (len == 0) || ($urandom_range(0, 4) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(8'($urandom), 1'b0, 1'b0, KnownNone);
        pace_sender();
      end
      send_beat(8'($urandom), 1'b1, (i == len - 1) && !empty_close, KnownNone);
      pace_sender();
    end
    if (empty_close) begin
      send_beat(8'($urandom), 1'b0, 1'b1, KnownNone);
      pace_sender();
    end
  endtask

  // Output stall pattern, with one long hold-off on request
  initial begin
    stall_left = 0;
    stall_mode = StallNone;
    forever begin
      @(negedge clk_i);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_stall_i  = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 2));
          stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
          StallRandom:   out_stall_i = 1'($urandom_range(0, 1));
          StallPeriodic: out_stall_i = (stall_left % 4) != 0;
          default:       out_stall_i = 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected digest beat: digest_word %h word_index %0d final_word %0b",
               digest_word_o, word_index_o, final_word_o);
        error_count++;
      end else begin
        expected_beat = pending_words.pop_front();
        if (digest_word_o !== expected_beat.word) begin
          $error("digest_word mismatch: expected %h, actual %h", expected_beat.word,
                 digest_word_o);
          error_count++;
        end
        if (word_index_o !== expected_beat.index) begin
          $error("word_index mismatch: expected %0d, actual %0d", expected_beat.index,
                 word_index_o);
          error_count++;
        end
        if (final_word_o !== expected_beat.last) begin
          $error("final_word mismatch: expected %0b, actual %0b", expected_beat.last,
                 final_word_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned row;
    int unsigned msg_count;
    error_count  = 0;
    bytes_sent   = 0;
    burst_left   = 0;
    msg_count    = 0;
    hold_out_req = 1'b0;
    restart_hash();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (row = 0; row < NumRows; row++) begin
      send_beat(DirectedRows[row].data, DirectedRows[row].has, DirectedRows[row].eom,
                DirectedRows[row].known);
      pace_sender();
    end
    drain_digests();

    // Hold the output while short messages keep coming, so input backs up
    hold_out_req = 1'b1;
    repeat (6) send_message($urandom_range(0, 3));
    drain_digests();

    while (bytes_sent < ByteTarget) begin
      send_message(pick_length());
      msg_count++;
      if (msg_count % 5 == 0) drain_digests();
    end
    drain_digests();
    repeat (DrainCycles) @(negedge clk_i);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/smd_pkg.sv
hw/rtl/smd_core.sv
hw/rtl/sha256_message_digest.sv
sim/sha256_message_digest_tb.sv
